// File: rtl/assert_macros.svh
// Assertion helper macros shared by the RTL of the segment/plane block.
// Included by files that carry concurrent assertions; no other content.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain invariant checked on every clock edge, disabled during reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

// File: rtl/spnh_pkg.sv
// Shared types, constants and helpers for the segment/plane nearest-hit block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spnh_pkg;
	localparam int unsigned CoordW = 32;
	localparam int unsigned WideW = 64;
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned QueuePtrW = 1;

	// configuration register indexes
	localparam logic [2:0] REG_NORMAL_X = 3'd0;
	localparam logic [2:0] REG_NORMAL_Y = 3'd1;
	localparam logic [2:0] REG_NORMAL_Z = 3'd2;
	localparam logic [2:0] REG_PLANE_OFFSET = 3'd3;
	localparam logic [2:0] REG_CENTER_X = 3'd4;
	localparam logic [2:0] REG_CENTER_Y = 3'd5;
	localparam logic [2:0] REG_CENTER_Z = 3'd6;

	// one classified segment, passed from front to back
	typedef struct packed {
		logic               start_set;
		logic               hit;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic        [63:0] an;
		logic        [63:0] ad;
	} job_t;

	// one result transaction
	typedef struct packed {
		logic               hit;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic               nearest_valid;
		logic signed [31:0] nearest_x;
		logic signed [31:0] nearest_y;
		logic signed [31:0] nearest_z;
	} result_t;

	// magnitude of a signed 66-bit value
	function automatic logic [63:0] mag66(input logic signed [65:0] v);
		logic [65:0] m;
		begin
			m = v[65] ? 66'(-v) : 66'(v);
			mag66 = m[63:0];
		end
	endfunction
endpackage
`default_nettype wire

// File: rtl/segment_plane_nearest_hit_core.sv
// Segment/plane intersection with nearest-hit tracking, Q16.16 fixed point.
// Instantiates spnh_front, spnh_queue and spnh_back; uses spnh_pkg.
//
// Usage:
//  - Input queue side: drive the segment fields and start_set, raise push while
//    full is low; each such edge is one transaction.
//  - Result queue side: while empty is low the result ports hold the oldest
//    result; pop with empty low takes it. One result per segment, in order.
//  - Configuration: cfg_we/cfg_index/cfg_data write one register per edge
//    (0..6: normal x/y/z, plane offset, center x/y/z); write while idle only.
//  - Steps: six products on one shared multiplier in the front, then sum and
//    hand-off; then the job queue; then in the back the result for a miss, or
//    for a hit a 33-step radix-2 divider for t, 3 interpolation steps, 6
//    distance steps, compare and result.
//  - The job queue lets the front work on the next segment during a division,
//    as long as the queue is not full.
//  - Reset clears all control state, the nearest hit and restores the register
//    defaults (normal = +z). A stalled receiver holds the result register; the
//    back end then waits, the queue fills and full stays high.
`timescale 1ns / 1ps
`default_nettype none
module segment_plane_nearest_hit_core import spnh_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] seg_start_x,
	input  wire logic signed [31:0] seg_start_y,
	input  wire logic signed [31:0] seg_start_z,
	input  wire logic signed [31:0] seg_end_x,
	input  wire logic signed [31:0] seg_end_y,
	input  wire logic signed [31:0] seg_end_z,
	input  wire logic               start_set,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    hit,
	output logic signed [31:0]      hit_x,
	output logic signed [31:0]      hit_y,
	output logic signed [31:0]      hit_z,
	output logic                    nearest_valid,
	output logic signed [31:0]      nearest_x,
	output logic signed [31:0]      nearest_y,
	output logic signed [31:0]      nearest_z,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	logic signed [31:0] nx_q, ny_q, nz_q, pd_q, cx_q, cy_q, cz_q;
	logic in_ready, fj_valid, fj_ready, bj_valid, bj_ready, res_valid;
	job_t fj, bj;
	result_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= 32'sd65536;
			pd_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NORMAL_X: nx_q <= cfg_data;
				REG_NORMAL_Y: ny_q <= cfg_data;
				REG_NORMAL_Z: nz_q <= cfg_data;
				REG_PLANE_OFFSET: pd_q <= cfg_data;
				REG_CENTER_X: cx_q <= cfg_data;
				REG_CENTER_Y: cy_q <= cfg_data;
				REG_CENTER_Z: cz_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign full = !in_ready;

	spnh_front u_front (
		.clk, .arst_n,
		.in_valid(push), .in_ready,
		.sx(seg_start_x), .sy(seg_start_y), .sz(seg_start_z),
		.ex(seg_end_x), .ey(seg_end_y), .ez(seg_end_z),
		.start_set,
		.nx(nx_q), .ny(ny_q), .nz(nz_q), .pd(pd_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	spnh_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
	);

	spnh_back u_back (
		.clk, .arst_n,
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.cx(cx_q), .cy(cy_q), .cz(cz_q),
		.res_valid, .res_pop(pop), .res
	);

	assign empty = !res_valid;
	assign hit = res.hit;
	assign hit_x = res.hit_x;
	assign hit_y = res.hit_y;
	assign hit_z = res.hit_z;
	assign nearest_valid = res.nearest_valid;
	assign nearest_x = res.nearest_x;
	assign nearest_y = res.nearest_y;
	assign nearest_z = res.nearest_z;
endmodule
`default_nettype wire

// File: rtl/spnh_front.sv
// Front end: products of the plane normal with segment start and direction,
// then classification (parallel / outside / hit) and t operands. Uses spnh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spnh_front import spnh_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] sx,
	input  wire logic signed [31:0] sy,
	input  wire logic signed [31:0] sz,
	input  wire logic signed [31:0] ex,
	input  wire logic signed [31:0] ey,
	input  wire logic signed [31:0] ez,
	input  wire logic               start_set,
	input  wire logic signed [31:0] nx,
	input  wire logic signed [31:0] ny,
	input  wire logic signed [31:0] nz,
	input  wire logic signed [31:0] pd,
	output logic                    job_valid,
	input  wire logic               job_ready,
	output job_t                    job
);
	// sequencer: one multiply per cycle, six products
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_SUM = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0] state_q;
	logic [2:0] step_q;
	logic signed [31:0] sx_q, sy_q, sz_q;
	logic signed [32:0] dx_q, dy_q, dz_q;
	logic start_q;
	logic signed [65:0] den_q, num_q;
	job_t job_q;

	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [64:0] prod;
	logic signed [65:0] prod_fl;
	logic signed [65:0] numv;
	logic [63:0] an, ad;
	logic ok;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = nx;
		mul_b = 33'(sx_q);
		case (step_q)
			3'd0: begin mul_a = nx; mul_b = dx_q; end
			3'd1: begin mul_a = ny; mul_b = dy_q; end
			3'd2: begin mul_a = nz; mul_b = dz_q; end
			3'd3: begin mul_a = nx; mul_b = 33'(sx_q); end
			3'd4: begin mul_a = ny; mul_b = 33'(sy_q); end
			3'd5: begin mul_a = nz; mul_b = 33'(sz_q); end
			default: begin mul_a = nx; mul_b = 33'(sx_q); end
		endcase
		prod = 65'(mul_a) * 65'(mul_b);
		// arithmetic shift floors toward minus infinity
		prod_fl = 66'(prod >>> 16);
	end

	// classification of the finished sums
	always_comb begin
		numv = -(num_q + 66'(pd));
		an = mag66(numv);
		ad = mag66(den_q);
		ok = (den_q != '0) && ((numv == '0) || (numv[65] == den_q[65])) && (an <= ad);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign job_valid = (state_q == ST_OUT);
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
						step_q <= '0;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: if (job_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			sx_q <= sx;
			sy_q <= sy;
			sz_q <= sz;
			dx_q <= 33'(ex) - 33'(sx);
			dy_q <= 33'(ey) - 33'(sy);
			dz_q <= 33'(ez) - 33'(sz);
			start_q <= start_set;
			den_q <= '0;
			num_q <= '0;
		end else if (state_q == ST_MUL) begin
			if (step_q < 3'd3) den_q <= den_q + prod_fl;
			else num_q <= num_q + prod_fl;
		end
		if (state_q == ST_SUM) begin
			job_q.start_set <= start_q;
			job_q.hit <= ok;
			job_q.sx <= sx_q;
			job_q.sy <= sy_q;
			job_q.sz <= sz_q;
			job_q.dx <= dx_q;
			job_q.dy <= dy_q;
			job_q.dz <= dz_q;
			job_q.an <= an;
			job_q.ad <= ad;
		end
	end
endmodule
`default_nettype wire

// File: rtl/spnh_queue.sv
// Two-entry job queue between the front and back ends. Uses spnh_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spnh_queue import spnh_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  job_t      wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output job_t      rd_data
);
	job_t mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wp_q, rp_q;
	logic [QueuePtrW:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'(QueueDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrW+1)'(do_wr) - (QueuePtrW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= 2'(QueueDepth), "queue count overflow")
	`ASSERT_IMPL(a_ptr_gap, clk, arst_n, cnt_q == '0 || cnt_q == 2'(QueueDepth),
		wp_q == rp_q, "queue pointers disagree with count")
	`ASSERT_IMPL(a_cnt_step, clk, arst_n, do_wr && !do_rd, ##1 cnt_q == $past(cnt_q) + 2'd1,
		"queue count did not grow on write")
endmodule
`default_nettype wire

// File: rtl/spnh_back.sv
// Back end: radix-2 divider for t, per-axis interpolation, squared distances
// and nearest-hit update; holds the result register. Uses spnh_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spnh_back import spnh_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	output logic                    job_ready,
	input  job_t                    job,
	input  wire logic signed [31:0] cx,
	input  wire logic signed [31:0] cy,
	input  wire logic signed [31:0] cz,
	output logic                    res_valid,
	input  wire logic               res_pop,
	output result_t                 res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_LERP = 3'd2;
	localparam logic [2:0] ST_DIST = 3'd3;
	localparam logic [2:0] ST_CMP = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic [2:0] ax_q;
	job_t j_q;
	logic [64:0] r_q;
	logic [32:0] t_q;
	logic signed [31:0] hx_q, hy_q, hz_q;
	logic [63:0] dn_q, db_q;
	logic res_full_q;
	result_t res_q;
	logic best_valid_q;
	logic signed [31:0] bx_q, by_q, bz_q;

	logic [64:0] r_sh, r_sub;
	logic r_ge;
	logic signed [32:0] d_sel;
	logic signed [31:0] s_sel;
	logic [32:0] d_mag;
	logic [65:0] lp;
	logic [32:0] off;
	logic signed [31:0] hpt;
	logic signed [31:0] p_sel, c_sel;
	logic signed [32:0] diff;
	logic [32:0] dmag;
	logic [65:0] sq;
	logic [63:0] sq_sat;
	logic [64:0] acc_sum;
	logic [63:0] acc_sat;
	logic phase_best;
	logic res_load;

	// division step: shift remainder, conditional subtract
	always_comb begin
		r_sh = (cnt_q == '0) ? r_q : {r_q[63:0], 1'b0};
		r_ge = r_sh >= {1'b0, j_q.ad};
		r_sub = r_ge ? r_sh - {1'b0, j_q.ad} : r_sh;
	end

	// interpolation of one axis: S + sign(D) * round(|D| * t)
	always_comb begin
		case (ax_q)
			3'd0: begin d_sel = j_q.dx; s_sel = j_q.sx; end
			3'd1: begin d_sel = j_q.dy; s_sel = j_q.sy; end
			default: begin d_sel = j_q.dz; s_sel = j_q.sz; end
		endcase
		d_mag = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
		lp = 66'(d_mag) * 66'(t_q) + 66'h0_8000_0000;
		off = lp[64:32];
		hpt = d_sel[32] ? 32'(33'(s_sel) - off) : 32'(33'(s_sel) + off);
	end

	// squared distance term; ax 0..2 new hit, 3..5 stored best
	always_comb begin
		phase_best = (ax_q >= 3'd3);
		case (ax_q)
			3'd0: begin p_sel = hx_q; c_sel = cx; end
			3'd1: begin p_sel = hy_q; c_sel = cy; end
			3'd2: begin p_sel = hz_q; c_sel = cz; end
			3'd3: begin p_sel = bx_q; c_sel = cx; end
			3'd4: begin p_sel = by_q; c_sel = cy; end
			default: begin p_sel = bz_q; c_sel = cz; end
		endcase
		diff = 33'(p_sel) - 33'(c_sel);
		dmag = diff[32] ? 33'(-diff) : 33'(diff);
		sq = 66'(dmag) * 66'(dmag);
		sq_sat = (sq[65:64] != '0) ? '1 : sq[63:0];
		acc_sum = phase_best ? 65'(db_q) + 65'(sq_sat) : 65'(dn_q) + 65'(sq_sat);
		acc_sat = acc_sum[64] ? '1 : acc_sum[63:0];
	end

	assign job_ready = (state_q == ST_IDLE);
	assign res_valid = res_full_q;
	assign res = res_q;
	// result register takes a new transaction once the old one is gone
	assign res_load = (state_q == ST_DONE) && (!res_full_q || res_pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_full_q <= 1'b0;
			best_valid_q <= 1'b0;
			bx_q <= '0;
			by_q <= '0;
			bz_q <= '0;
			cnt_q <= '0;
			ax_q <= '0;
		end else begin
			if (res_load) res_full_q <= 1'b1;
			else if (res_pop) res_full_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						cnt_q <= '0;
						ax_q <= '0;
						if (job.start_set) begin
							best_valid_q <= 1'b0;
							bx_q <= '0;
							by_q <= '0;
							bz_q <= '0;
						end
						state_q <= job.hit ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) state_q <= ST_LERP;
				end
				ST_LERP: begin
					if (ax_q == 3'd2) begin
						ax_q <= '0;
						state_q <= ST_DIST;
					end else begin
						ax_q <= ax_q + 3'd1;
					end
				end
				ST_DIST: begin
					ax_q <= ax_q + 3'd1;
					if (ax_q == 3'd5) state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!best_valid_q || dn_q < db_q) begin
						best_valid_q <= 1'b1;
						bx_q <= hx_q;
						by_q <= hy_q;
						bz_q <= hz_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				j_q <= job;
				r_q <= {1'b0, job.an};
				t_q <= '0;
				hx_q <= '0;
				hy_q <= '0;
				hz_q <= '0;
				dn_q <= '0;
				db_q <= '0;
			end
			ST_DIV: begin
				r_q <= r_sub;
				t_q <= {t_q[31:0], r_ge};
			end
			ST_LERP: begin
				case (ax_q)
					3'd0: hx_q <= hpt;
					3'd1: hy_q <= hpt;
					default: hz_q <= hpt;
				endcase
			end
			ST_DIST: begin
				if (phase_best) db_q <= acc_sat;
				else dn_q <= acc_sat;
			end
			ST_DONE: begin
				if (res_load) begin
					res_q.hit <= j_q.hit;
					res_q.hit_x <= hx_q;
					res_q.hit_y <= hy_q;
					res_q.hit_z <= hz_q;
					res_q.nearest_valid <= best_valid_q;
					res_q.nearest_x <= bx_q;
					res_q.nearest_y <= by_q;
					res_q.nearest_z <= bz_q;
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_IMPL(a_div_len, clk, arst_n, state_q == ST_DIV, cnt_q <= 6'd32,
		"divider ran past 33 steps")
	`ASSERT_IMPL(a_nohit_zero, clk, arst_n, state_q == ST_DONE && !j_q.hit,
		hx_q == '0 && hy_q == '0 && hz_q == '0, "miss carries nonzero point")
	`ASSERT_IMPL(a_t_max, clk, arst_n, state_q == ST_LERP,
		t_q <= 33'h1_0000_0000, "t above one")
endmodule
`default_nettype wire
